@@ src/jfop_pkg.sv @@
// ----------------------------------------------------------------------------
// jfop_pkg
// Shared types and codes for the flat JSON string-object parser: the beat
// structs of both channels, the parse phase codes and the verdict codes.
// ----------------------------------------------------------------------------
package jfop_pkg;

   // One input beat: a raw document byte and the end-of-document flag.
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_code;
      logic       in_value;
      logic       string_end;
      logic       doc_done;
      logic [1:0] doc_status;
   } rsp_type;

   // Grammar position.
   typedef enum logic [3:0] {
      PH_OPEN      = 4'd0,
      PH_FIRST     = 4'd1,
      PH_KEY       = 4'd2,
      PH_KEY_ESC   = 4'd3,
      PH_KEY_HEX   = 4'd4,
      PH_COLON     = 4'd5,
      PH_VAL_START = 4'd6,
      PH_VAL       = 4'd7,
      PH_VAL_ESC   = 4'd8,
      PH_VAL_HEX   = 4'd9,
      PH_AFTER_VAL = 4'd10,
      PH_NEXT_KEY  = 4'd11,
      PH_TRAIL     = 4'd12
   } phase_type;

   // Verdict reported with every result beat.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ACCEPTED  = 2'd1;
   localparam logic [1:0] STAT_MALFORMED = 2'd2;

   // Largest code point a four-digit escape may carry.
   localparam logic [15:0] CODE_LIMIT = 16'h007f;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      phase_type   phase;
      logic [15:0] hex_accum;
      logic [1:0]  hex_digits_seen;
      logic        error_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_OPEN,
      hex_accum:       16'h0000,
      hex_digits_seen: 2'd0,
      error_seen:      1'b0
   };

endpackage

@@ src/jfop_step.sv @@
// ----------------------------------------------------------------------------
// jfop_step
// Combinational transition of the parser: from the current state and one
// input byte it forms the next state and the result beat for that byte.
// ----------------------------------------------------------------------------
module jfop_step
   import jfop_pkg::*;
(
   input  state_type cur_state,
   input  req_type   req,
   output state_type nxt_state,
   output rsp_type   rsp
);

   logic       is_ws;
   logic       hex_ok;
   logic [3:0] hex_val;
   logic       is_v;
   phase_type  base_ph;
   phase_type  esc_ph;
   phase_type  hex_ph;
   logic [15:0] acc_next;
   logic       cv;
   logic       send;
   logic       val;
   logic       err;
   logic [7:0] code;
   logic [7:0] b;

   assign b = req.byte_in;
   assign is_ws = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         hex_val = 4'(b - 8'h30);
      end else if ((b >= 8'h61) && (b <= 8'h66)) begin
         hex_val = 4'(b - 8'h57);
      end else if ((b >= 8'h41) && (b <= 8'h46)) begin
         hex_val = 4'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_v = (cur_state.phase == PH_VAL_START) || (cur_state.phase == PH_VAL) ||
                 (cur_state.phase == PH_VAL_ESC) || (cur_state.phase == PH_VAL_HEX);
   assign base_ph  = is_v ? PH_VAL : PH_KEY;
   assign esc_ph   = is_v ? PH_VAL_ESC : PH_KEY_ESC;
   assign hex_ph   = is_v ? PH_VAL_HEX : PH_KEY_HEX;
   assign acc_next = {cur_state.hex_accum[11:0], hex_val};

   always_comb begin
      nxt_state = cur_state;
      cv   = 1'b0;
      send = 1'b0;
      val  = 1'b0;
      err  = 1'b0;
      code = 8'h00;
      if (!cur_state.error_seen) begin
         unique case (cur_state.phase)
            PH_OPEN: begin
               if (b == "{") nxt_state.phase = PH_FIRST;
               else if (!is_ws) err = 1'b1;
            end
            PH_FIRST, PH_NEXT_KEY: begin
               if (b == "\"") nxt_state.phase = PH_KEY;
               else if ((cur_state.phase == PH_FIRST) && (b == "}")) nxt_state.phase = PH_TRAIL;
               else if (!is_ws) err = 1'b1;
            end
            PH_COLON: begin
               if (b == ":") nxt_state.phase = PH_VAL_START;
               else if (!is_ws) err = 1'b1;
            end
            PH_VAL_START: begin
               if (b == "\"") nxt_state.phase = PH_VAL;
               else if (!is_ws) err = 1'b1;
            end
            PH_AFTER_VAL: begin
               if (b == "}") nxt_state.phase = PH_TRAIL;
               else if (b == ",") nxt_state.phase = PH_NEXT_KEY;
               else if (!is_ws) err = 1'b1;
            end
            PH_TRAIL: begin
               if (!is_ws) err = 1'b1;
            end
            PH_KEY, PH_VAL: begin
               val = is_v;
               if (b == "\"") begin
                  send = 1'b1;
                  nxt_state.phase = is_v ? PH_AFTER_VAL : PH_COLON;
               end else if (b == "\\") begin
                  nxt_state.phase = esc_ph;
               end else begin
                  cv   = 1'b1;
                  code = b;
               end
            end
            PH_KEY_ESC, PH_VAL_ESC: begin
               val = is_v;
               nxt_state.phase = base_ph;
               cv = 1'b1;
               case (b)
                  "\"":    code = 8'h22;
                  "\\":    code = 8'h5c;
                  "/":     code = 8'h2f;
                  "b":     code = 8'h08;
                  "f":     code = 8'h0c;
                  "n":     code = 8'h0a;
                  "r":     code = 8'h0d;
                  "t":     code = 8'h09;
                  "u": begin
                     cv = 1'b0;
                     nxt_state.hex_accum       = 16'h0000;
                     nxt_state.hex_digits_seen = 2'd0;
                     nxt_state.phase           = hex_ph;
                  end
                  default: begin
                     cv  = 1'b0;
                     err = 1'b1;
                     nxt_state.phase = cur_state.phase;
                  end
               endcase
            end
            PH_KEY_HEX, PH_VAL_HEX: begin
               val = is_v;
               if (!hex_ok) begin
                  err = 1'b1;
               end else begin
                  nxt_state.hex_accum = acc_next;
                  if (cur_state.hex_digits_seen == 2'd3) begin
                     nxt_state.hex_digits_seen = 2'd0;
                     if (acc_next <= CODE_LIMIT) begin
                        cv   = 1'b1;
                        code = acc_next[7:0];
                        nxt_state.phase = base_ph;
                     end else begin
                        err = 1'b1;
                     end
                  end else begin
                     nxt_state.hex_digits_seen = cur_state.hex_digits_seen + 2'd1;
                  end
               end
            end
            default: err = 1'b1;
         endcase
         if (err) begin
            nxt_state.error_seen = 1'b1;
            cv   = 1'b0;
            send = 1'b0;
            code = 8'h00;
         end
      end

      rsp.char_valid = cv;
      rsp.char_code  = code;
      rsp.in_value   = (cv || send) && val;
      rsp.string_end = send;
      rsp.doc_done   = req.last_byte;
      if (req.last_byte) begin
         rsp.doc_status = (!nxt_state.error_seen && (nxt_state.phase == PH_TRAIL)) ?
                          STAT_ACCEPTED : STAT_MALFORMED;
         nxt_state = STATE_RESET;
      end else begin
         rsp.doc_status = nxt_state.error_seen ? STAT_MALFORMED : STAT_OK;
      end
   end

endmodule

@@ src/json_flat_object_parser.sv @@
// ----------------------------------------------------------------------------
// json_flat_object_parser
// Streaming checker and decoder for a flat JSON object of string keys and
// string values, one document byte per beat, one result beat per byte.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_type (byte_in, last_byte)
//   rsp_      out        rsp_valid / rsp_stall   rsp_type (decoded char, verdict)
//
// The transition logic sits between the parser state register and the result
// register, so a byte can be taken on every clock while the input is not
// stalled, and its result appears on the next one.
// Reset is synchronous and returns the parser to "expect opening brace" with
// the error flag clear and the result register empty.
// A stalled result holds in place; the input is stalled only while a result
// waits and is not being taken in that same cycle.
//
module json_flat_object_parser
   import jfop_pkg::*;
(
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_accept;

   // The result register frees up in the same cycle its beat is taken, so
   // the input only waits when a result is blocked downstream.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Byte transition: next parser state and the result beat for this byte.
   jfop_step u_step (
      .cur_state (state_ff),
      .req       (req_payload),
      .nxt_state (state_in),
      .rsp       (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   // The result payload needs no reset; it is only looked at when valid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ src/jfop_checker.sv @@
// ----------------------------------------------------------------------------
// jfop_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jfop_checker
   import jfop_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A blocked result beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   // Acceptance is only ever reported on the last byte of a document.
   a_accept_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.doc_status == STAT_ACCEPTED) |-> rsp_payload.doc_done)
      else $error("document accepted before its last byte");

   // Mid-document, decoded output never follows a detected error.
   a_no_output_after_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.doc_done &&
      (rsp_payload.char_valid || rsp_payload.string_end)
      |-> rsp_payload.doc_status == STAT_OK)
      else $error("string output reported together with an error");

   // A closing quote never carries a character of its own.
   a_char_or_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.char_valid && rsp_payload.string_end))
      else $error("character and string end in the same beat");

   // The input is held off only while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with no blocked result");

endmodule

bind json_flat_object_parser jfop_checker u_jfop_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ verif/tb_json_flat_object_parser.sv @@
// ----------------------------------------------------------------------------
// tb_json_flat_object_parser
// Streams JSON documents into the parser one byte per beat. The documents are
// well-formed objects with random content, the same objects with one flaw,
// and short runs of noise. A behavioral model of the grammar predicts every
// result beat, and each result beat is checked field by field. Both channels
// idle at random in several phases, and one long receiver hold-off makes the
// block stall its input.
// ----------------------------------------------------------------------------
module tb_json_flat_object_parser;
   timeunit 1ns;
   timeprecision 1ps;
   import jfop_pkg::*;

   // Length of the receiver hold-off in the back-pressure test.
   localparam int HOLD_OFF_CYCLES = 60;
   // Upper bound on the wait for outstanding results at the end of the run.
   localparam int DRAIN_LIMIT     = 20000;
   // The block holds one result register, so this short settle wait is enough
   // to flush anything that is still in flight.
   localparam int SETTLE_CYCLES   = 4;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   json_flat_object_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser state as the testbench sees it, advanced once per accepted beat.
   state_type  model_state = STATE_RESET;
   // Predicted result beats, oldest first.
   rsp_type    pending_results[$];
   // The document being built, one byte per entry.
   logic [7:0] doc_bytes[$];

   // The first eight letters are the single-letter escapes; "u" comes last.
   string escape_letters = "\"\\/bfnrtu";
   // Bytes that steer the parser somewhere; noise draws on them often.
   string grammar_chars  = "{}\":,\\ u0";

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   // The test toggles hold_trigger, and the stall process then counts out
   // the hold-off on its own.
   logic hold_trigger  = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;
   // Set while the next string should carry one faulty escape.
   logic flaw_pending  = 1'b0;

   int error_count     = 0;
   int docs_sent       = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int docs_accepted   = 0;
   int docs_malformed  = 0;
   int chars_decoded   = 0;

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   function automatic logic is_hex_digit(input logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
   endfunction

   // Advances the parser state by one byte and returns the result beat
   // that the byte should produce.
   function automatic rsp_type parse_byte(input logic [7:0] b, input logic last);
      rsp_type     r;
      phase_type   ph;
      logic        emit;
      logic        close;
      logic        fault;
      logic        for_value;
      logic [7:0]  code;
      logic [15:0] acc;
      logic [3:0]  nib;

      ph        = model_state.phase;
      for_value = ph >= PH_VAL_START && ph <= PH_VAL_HEX;
      emit      = 1'b0;
      close     = 1'b0;
      fault     = 1'b0;
      code      = 8'h00;
      nib       = 4'h0;

      if (!model_state.error_seen) begin
         case (ph)
            PH_OPEN: begin
               if (b == "{") model_state.phase = PH_FIRST;
               else if (!is_space(b)) fault = 1'b1;
            end
            PH_FIRST, PH_NEXT_KEY: begin
               if (b == "\"") model_state.phase = PH_KEY;
               else if (ph == PH_FIRST && b == "}") model_state.phase = PH_TRAIL;
               else if (!is_space(b)) fault = 1'b1;
            end
            PH_COLON: begin
               if (b == ":") model_state.phase = PH_VAL_START;
               else if (!is_space(b)) fault = 1'b1;
            end
            PH_VAL_START: begin
               if (b == "\"") model_state.phase = PH_VAL;
               else if (!is_space(b)) fault = 1'b1;
            end
            PH_AFTER_VAL: begin
               if (b == "}") model_state.phase = PH_TRAIL;
               else if (b == ",") model_state.phase = PH_NEXT_KEY;
               else if (!is_space(b)) fault = 1'b1;
            end
            PH_TRAIL: begin
               if (!is_space(b)) fault = 1'b1;
            end
            PH_KEY, PH_VAL: begin
               if (b == "\"") begin
                  close = 1'b1;
                  model_state.phase = for_value ? PH_AFTER_VAL : PH_COLON;
               end else if (b == "\\") begin
                  model_state.phase = for_value ? PH_VAL_ESC : PH_KEY_ESC;
               end else begin
                  emit = 1'b1;
                  code = b;
               end
            end
            PH_KEY_ESC, PH_VAL_ESC: begin
               emit = 1'b1;
               case (b)
                  "\"", "\\", "/": code = b;
                  "b": code = 8'h08;
                  "f": code = 8'h0c;
                  "n": code = 8'h0a;
                  "r": code = 8'h0d;
                  "t": code = 8'h09;
                  "u": begin
                     emit = 1'b0;
                     model_state.hex_accum       = '0;
                     model_state.hex_digits_seen = '0;
                  end
                  default: begin
                     emit  = 1'b0;
                     fault = 1'b1;
                  end
               endcase
               if (emit) model_state.phase = for_value ? PH_VAL : PH_KEY;
               else if (!fault) model_state.phase = for_value ? PH_VAL_HEX : PH_KEY_HEX;
            end
            PH_KEY_HEX, PH_VAL_HEX: begin
               if (!is_hex_digit(b)) begin
                  fault = 1'b1;
               end else begin
                  // Digits and both letter cases share the low nibble layout.
                  nib = (b <= "9") ? b[3:0] : b[3:0] + 4'd9;
                  acc = {model_state.hex_accum[11:0], nib};
                  model_state.hex_accum = acc;
                  if (model_state.hex_digits_seen == 2'd3) begin
                     model_state.hex_digits_seen = 2'd0;
                     if (acc <= CODE_LIMIT) begin
                        emit = 1'b1;
                        code = acc[7:0];
                        model_state.phase = for_value ? PH_VAL : PH_KEY;
                     end else begin
                        fault = 1'b1;
                     end
                  end else begin
                     model_state.hex_digits_seen = model_state.hex_digits_seen + 2'd1;
                  end
               end
            end
            default: fault = 1'b1;
         endcase
         if (fault) begin
            model_state.error_seen = 1'b1;
            emit  = 1'b0;
            close = 1'b0;
         end
      end

      r.char_valid = emit;
      r.char_code  = emit ? code : 8'h00;
      r.in_value   = (emit || close) && for_value;
      r.string_end = close;
      r.doc_done   = last;
      if (last) begin
         r.doc_status = (!model_state.error_seen && model_state.phase == PH_TRAIL) ?
                        STAT_ACCEPTED : STAT_MALFORMED;
         model_state = STATE_RESET;
      end else begin
         r.doc_status = model_state.error_seen ? STAT_MALFORMED : STAT_OK;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Document construction
   // ------------------------------------------------------------------------

   // Appends one byte to the end of the document under construction.
   task automatic add_byte(input logic [7:0] b);
      doc_bytes.insert(doc_bytes.size(), b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return ($urandom_range(1) ? "a" : "A") + n - 4'd10;
   endfunction

   // Adds the leading hex digits of a 16-bit code.
   task automatic push_hex(input logic [15:0] code, input int digits);
      for (int i = 0; i < digits; i++) add_byte(hex_char(code[15 - 4*i -: 4]));
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Zero to two whitespace bytes, drawn from all six kinds.
   task automatic append_space();
      int k;
      repeat ($urandom_range(2)) begin
         k = $urandom_range(5);
         add_byte(k == 5 ? 8'h20 : 8'(8'h09 + k));
      end
   endtask

   // A quoted string of plain bytes, single-letter escapes and \u escapes.
   // When a flaw is pending, the string also gets one bad escape.
   task automatic append_string();
      logic [7:0] b;
      logic       clash;
      add_byte("\"");
      repeat ($urandom_range(4)) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               // Any byte at all passes through, control bytes and the
               // upper half included, except the quote and the backslash.
               do b = 8'($urandom_range(255)); while (b == "\"" || b == "\\");
               add_byte(b);
            end
            6, 7, 8: begin
               add_byte("\\");
               add_byte(escape_letters[$urandom_range(7)]);
            end
            default: begin
               add_byte("\\");
               add_byte("u");
               push_hex(16'($urandom_range(16'h007f)), 4);
            end
         endcase
      end
      if (flaw_pending) begin
         flaw_pending = 1'b0;
         add_byte("\\");
         case ($urandom_range(2))
            0: begin
               // A byte that names no escape.
               do begin
                  b = 8'($urandom_range(255));
                  clash = 1'b0;
                  for (int k = 0; k < escape_letters.len(); k++)
                     if (b == escape_letters[k]) clash = 1'b1;
               end while (clash);
               add_byte(b);
            end
            1: begin
               // Four good digits, but the code is above the limit.
               add_byte("u");
               push_hex(16'($urandom_range(16'hffff, 16'h0080)), 4);
            end
            default: begin
               // Fewer than four digits, then a byte that is no digit.
               add_byte("u");
               push_hex(16'($urandom), int'($urandom_range(3)));
               do b = 8'($urandom_range(255)); while (is_hex_digit(b));
               add_byte(b);
            end
         endcase
      end
      add_byte("\"");
   endtask

   // Most documents are well-formed objects. Some carry a bad escape, some
   // are damaged after the fact, and the rest are short runs of noise.
   task automatic build_document();
      int         kind;
      int         cut;
      int         pairs;
      logic [7:0] b;
      doc_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(8, 1)) begin
            if ($urandom_range(2) == 0) b = 8'($urandom_range(255));
            else b = grammar_chars[$urandom_range(grammar_chars.len() - 1)];
            add_byte(b);
         end
      end else begin
         flaw_pending = kind >= 70 && kind < 80;
         pairs = $urandom_range(3);
         append_space();
         add_byte("{");
         append_space();
         for (int i = 0; i < pairs; i++) begin
            if (i != 0) begin
               append_space();
               add_byte(",");
               append_space();
            end
            append_string();
            append_space();
            add_byte(":");
            append_space();
            append_string();
         end
         append_space();
         add_byte("}");
         append_space();
         flaw_pending = 1'b0;
         if (kind >= 80) begin
            case ($urandom_range(2))
               0: doc_bytes[$urandom_range(doc_bytes.size() - 1)] = 8'($urandom_range(255));
               1: begin
                  // Cut the document short, so the last byte lands mid-parse.
                  cut = $urandom_range(doc_bytes.size() - 1, 1);
                  while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
               end
               default: add_byte(8'($urandom_range(8'hff, 8'h21)));
            endcase
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offers one beat and returns at the clock edge that takes it. Idle
   // cycles come before the beat is offered, so valid only falls in a cycle
   // that carries no beat.
   task automatic send_beat(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{byte_in: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_document();
      for (int i = 0; i < doc_bytes.size(); i++)
         send_beat(doc_bytes[i], i == doc_bytes.size() - 1);
      docs_sent++;
   endtask

   task automatic run_documents(input int byte_goal);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         build_document();
         send_document();
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      // An empty object with space inside the braces.
      doc_bytes.delete();
      push_text("{ }");
      send_document();
      // The largest code that \u allows as a key, and a value with an escaped
      // slash, the zero byte and the all-ones byte.
      doc_bytes.delete();
      push_text("{\"\\u007F\":\"\\/");
      add_byte(8'h00);
      add_byte(8'hff);
      push_text("\"}");
      send_document();
      // The smallest code that is too large; the document ends on it.
      doc_bytes.delete();
      push_text("{\"\\u0080");
      send_document();
      // A single stray byte is a whole document on its own.
      doc_bytes.delete();
      push_text("x");
      send_document();
   endtask

   task automatic test_steady_stream();
      send_idle_pct = 0;
      stall_pct    <= 0;
      run_documents(120);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 73;
      stall_pct    <= 0;
      run_documents(100);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      stall_pct    <= 73;
      run_documents(100);
   endtask

   task automatic test_both_sides_idle();
      send_idle_pct = 26;
      stall_pct    <= 26;
      run_documents(100);
   endtask

   // The receiver holds off while the sender keeps offering beats, so the
   // result register fills and the block has to stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct    <= 0;
      hold_trigger <= ~hold_trigger;
      run_documents(80);
   endtask

   // ------------------------------------------------------------------------
   // Receiver and checking
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   // Every beat the block takes gets its prediction queued at that edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_results.insert(pending_results.size(),
                                parse_byte(req_payload.byte_in, req_payload.last_byte));
   end

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no byte outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("char_valid", 8'(want.char_valid), 8'(rsp_payload.char_valid));
            compare_field("char_code",  want.char_code,      rsp_payload.char_code);
            compare_field("in_value",   8'(want.in_value),   8'(rsp_payload.in_value));
            compare_field("string_end", 8'(want.string_end), 8'(rsp_payload.string_end));
            compare_field("doc_done",   8'(want.doc_done),   8'(rsp_payload.doc_done));
            compare_field("doc_status", 8'(want.doc_status), 8'(rsp_payload.doc_status));
            results_checked++;
            if (want.char_valid) chars_decoded++;
            if (want.doc_done) begin
               if (want.doc_status == STAT_ACCEPTED) docs_accepted++;
               else docs_malformed++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      int wait_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_steady_stream();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_sides_idle();
      test_backpressure();

      req_valid <= 1'b0;
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected result beats never arrived", pending_results.size());
         error_count++;
      end

      $display("Streamed %0d documents in %0d byte beats: %0d accepted, %0d malformed.",
               docs_sent, bytes_sent, docs_accepted, docs_malformed);
      $display("Checked %0d result beats, %0d of them decoded characters.",
               results_checked, chars_decoded);
      if (error_count == 0) begin
         $display("tb_json_flat_object_parser: PASS");
      end else begin
         $display("tb_json_flat_object_parser: FAIL");
      end
      $finish;
   end

   // This timeout lies far beyond what a correct run needs.
   initial begin
      #2_000_000;
      $display("tb_json_flat_object_parser: FAIL");
      $finish;
   end

endmodule
